// ----- hw/rtl/tmp_pkg.sv -----
package tmp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 16;
    localparam int TALL_W     = DATA_W + 2;
    localparam int DIV_STAGES = STEP_W / 2;
    localparam int DIVN_W     = 64;
    localparam int DIVD_W     = DATA_W + 1;

    typedef enum logic [1:0] {
        REG_DIST  = 2'd0,
        REG_ACCEL = 2'd1,
        REG_SPEED = 2'd2,
        REG_COUNT = 2'd3
    } tmp_reg_t;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2
    } tmp_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PICK,
        ST_SQRT,
        ST_DIV_D1,
        ST_DIV_T1,
        ST_DIV_T2,
        ST_DIV_Q
    } tmp_state_t;

    // Profile constants derived from the configuration
    typedef struct packed {
        logic                ready;
        logic [DATA_W-1:0]   distance;
        logic [STEP_W-1:0]   count;
        logic [DATA_W-1:0]   a_eff;
        logic [DATA_W-1:0]   v_eff;
        logic [DATA_W-1:0]   t1;
        logic [DATA_W-1:0]   t2;
        logic [TALL_W-1:0]   tall;
        logic [TALL_W-1:0]   q0;
        logic [STEP_W-1:0]   r0;
        logic [STEP_W-1:0]   dn;
    } tmp_setup_t;

    function automatic logic [DATA_W-1:0] sat32(input logic [63:0] v);
        logic [DATA_W-1:0] r;
        r = (|v[63:DATA_W]) ? '1 : v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/tmp_div.sv -----
module tmp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          abort,
    input  logic [tmp_pkg::DIVN_W-1:0]    dividend,
    input  logic [tmp_pkg::DIVD_W-1:0]    divisor,
    output logic                          done,
    output logic [tmp_pkg::DIVN_W-1:0]    quot,
    output logic [tmp_pkg::DIVD_W-1:0]    rem
);
    localparam int CW = $clog2(tmp_pkg::DIVN_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [tmp_pkg::DIVN_W-1:0]    quot_reg;
    logic [tmp_pkg::DIVD_W-1:0]    rem_reg;
    logic [tmp_pkg::DIVD_W-1:0]    dvs_reg;
    logic [tmp_pkg::DIVD_W:0]      sh;
    logic                          ge;

    // One quotient bit per cycle, restoring
    always_comb begin
        sh = {rem_reg, quot_reg[tmp_pkg::DIVN_W-1]};
        ge = (sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (abort) begin
                busy_reg <= 1'b0;
            end else if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(tmp_pkg::DIVN_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[tmp_pkg::DIVN_W-2:0], ge};
            rem_reg  <= ge ? tmp_pkg::DIVD_W'(sh - {1'b0, dvs_reg})
                           : sh[tmp_pkg::DIVD_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ----- hw/rtl/tmp_setup.sv -----
module tmp_setup (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output tmp_pkg::tmp_setup_t   setup
);
    localparam int F = tmp_pkg::FRAC_BITS;
    localparam int W = tmp_pkg::DATA_W;

    tmp_pkg::tmp_state_t state_reg, state_next;

    logic [W-1:0]          dist_reg, accel_reg, speed_reg;
    logic [tmp_pkg::STEP_W-1:0] count_reg;
    logic [W-1:0]          a_eff, v_eff;
    logic [63:0]           xa_reg, vv_reg, d1_reg;
    logic                  tri_reg;
    logic [63:0]           s_rem_reg, s_res_reg, s_bit_reg, s_trial;
    logic [4:0]            s_cnt_reg;
    logic [W-1:0]          t1_reg, t2_reg;
    logic [tmp_pkg::TALL_W-1:0] q0_reg, tall;
    logic [tmp_pkg::STEP_W-1:0] r0_reg, dn;
    logic                  div_run_reg;
    logic                  div_start, div_done, div_state;
    logic [tmp_pkg::DIVN_W-1:0] div_dividend, div_quot;
    logic [tmp_pkg::DIVD_W-1:0] div_divisor, div_rem;

    assign cfg_ready = 1'b1;
    assign a_eff = (accel_reg == '0) ? W'(1) : accel_reg;
    assign v_eff = (speed_reg == '0) ? W'(1) : speed_reg;
    assign dn    = (count_reg >= 16'd2) ? count_reg - 1'b1 : 16'd1;
    assign tall  = {1'b0, t1_reg, 1'b0} + {2'b0, t2_reg};
    assign s_trial = s_res_reg + s_bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg  <= '0;
            accel_reg <= W'(1) << F;
            speed_reg <= W'(1) << F;
            count_reg <= 16'd100;
        end else if (cfg_valid) begin
            unique case (tmp_pkg::tmp_reg_t'(cfg_index))
                tmp_pkg::REG_DIST:  dist_reg  <= cfg_data;
                tmp_pkg::REG_ACCEL: accel_reg <= cfg_data;
                tmp_pkg::REG_SPEED: speed_reg <= cfg_data;
                tmp_pkg::REG_COUNT: count_reg <= cfg_data[tmp_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmp_pkg::ST_IDLE:   state_next = tmp_pkg::ST_IDLE;
            tmp_pkg::ST_MUL:    state_next = tmp_pkg::ST_PICK;
            tmp_pkg::ST_PICK:   state_next = (vv_reg > xa_reg) ? tmp_pkg::ST_SQRT
                                                               : tmp_pkg::ST_DIV_D1;
            tmp_pkg::ST_SQRT:   if (s_cnt_reg == '0) state_next = tmp_pkg::ST_DIV_T1;
            tmp_pkg::ST_DIV_D1: if (div_done) state_next = tmp_pkg::ST_DIV_T1;
            tmp_pkg::ST_DIV_T1: if (div_done) state_next = tri_reg ? tmp_pkg::ST_DIV_Q
                                                                    : tmp_pkg::ST_DIV_T2;
            tmp_pkg::ST_DIV_T2: if (div_done) state_next = tmp_pkg::ST_DIV_Q;
            tmp_pkg::ST_DIV_Q:  if (div_done) state_next = tmp_pkg::ST_IDLE;
            default:            state_next = tmp_pkg::ST_MUL;
        endcase
        if (cfg_valid) state_next = tmp_pkg::ST_MUL;
    end

    always_comb begin
        div_state    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (state_reg)
            tmp_pkg::ST_DIV_D1: begin
                div_state    = 1'b1;
                div_dividend = vv_reg;
                div_divisor  = {a_eff, 1'b0};
            end
            tmp_pkg::ST_DIV_T1: begin
                div_state    = 1'b1;
                div_dividend = tri_reg ? (s_res_reg << F) : ({32'b0, v_eff} << F);
                div_divisor  = {1'b0, a_eff};
            end
            tmp_pkg::ST_DIV_T2: begin
                div_state    = 1'b1;
                div_dividend = ({32'b0, dist_reg} - {d1_reg[62:0], 1'b0}) << F;
                div_divisor  = {1'b0, v_eff};
            end
            tmp_pkg::ST_DIV_Q: begin
                div_state    = 1'b1;
                div_dividend = {{(64-tmp_pkg::TALL_W){1'b0}}, tall};
                div_divisor  = {{(tmp_pkg::DIVD_W-tmp_pkg::STEP_W){1'b0}}, dn};
            end
            default: ;
        endcase
        div_start = div_state && !div_run_reg && !cfg_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tmp_pkg::ST_MUL;
            div_run_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid)      div_run_reg <= 1'b0;
            else if (div_start) div_run_reg <= 1'b1;
            else if (div_done)  div_run_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            tmp_pkg::ST_MUL: begin
                xa_reg <= 64'(dist_reg) * 64'(a_eff);
                vv_reg <= 64'(v_eff) * 64'(v_eff);
            end
            tmp_pkg::ST_PICK: begin
                tri_reg   <= (vv_reg > xa_reg);
                s_rem_reg <= xa_reg;
                s_res_reg <= '0;
                s_bit_reg <= 64'd1 << 62;
                s_cnt_reg <= 5'd31;
                t2_reg    <= '0;
            end
            tmp_pkg::ST_SQRT: begin
                // One result bit per cycle
                if (s_rem_reg >= s_trial) begin
                    s_rem_reg <= s_rem_reg - s_trial;
                    s_res_reg <= (s_res_reg >> 1) + s_bit_reg;
                end else begin
                    s_res_reg <= s_res_reg >> 1;
                end
                s_bit_reg <= s_bit_reg >> 2;
                s_cnt_reg <= s_cnt_reg - 1'b1;
            end
            tmp_pkg::ST_DIV_D1: if (div_done) d1_reg <= div_quot;
            tmp_pkg::ST_DIV_T1: if (div_done) t1_reg <= tmp_pkg::sat32(div_quot);
            tmp_pkg::ST_DIV_T2: if (div_done) t2_reg <= tmp_pkg::sat32(div_quot);
            tmp_pkg::ST_DIV_Q: begin
                if (div_done) begin
                    q0_reg <= div_quot[tmp_pkg::TALL_W-1:0];
                    r0_reg <= div_rem[tmp_pkg::STEP_W-1:0];
                end
            end
            default: ;
        endcase
    end

    tmp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .abort    (cfg_valid),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb begin
        setup.ready    = (state_reg == tmp_pkg::ST_IDLE);
        setup.distance = dist_reg;
        setup.count    = count_reg;
        setup.a_eff    = a_eff;
        setup.v_eff    = v_eff;
        setup.t1       = t1_reg;
        setup.t2       = t2_reg;
        setup.tall     = tall;
        setup.q0       = q0_reg;
        setup.r0       = r0_reg;
        setup.dn       = dn;
    end

endmodule

// ----- hw/rtl/tmp_time.sv -----
module tmp_time (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [tmp_pkg::STEP_W-1:0]    in_index,
    input  tmp_pkg::tmp_setup_t           setup,
    output logic                          out_valid,
    output logic [tmp_pkg::TALL_W-1:0]    out_t,
    output logic                          out_big
);
    localparam int NS = tmp_pkg::DIV_STAGES;
    localparam int SW = tmp_pkg::STEP_W;
    localparam int TW = tmp_pkg::TALL_W;
    localparam int QW = TW + SW;

    logic            s0_valid_reg, s0_big_reg;
    logic [QW-1:0]   s0_qi_reg;
    logic [2*SW-1:0] s0_ri_reg;

    logic            dv_valid_reg [NS];
    logic            dv_big_reg   [NS];
    logic [SW-1:0]   dv_rem_reg   [NS];
    logic [SW-1:0]   dv_lo_reg    [NS];
    logic [SW-1:0]   dv_quot_reg  [NS];
    logic [TW-1:0]   dv_qi_reg    [NS];

    logic            t_valid_reg, t_big_reg;
    logic [TW-1:0]   t_reg;

    // t = q0*i + (r0*i)/dn, where tall = q0*dn + r0
    always_ff @(posedge aclk) begin
        if (!aresetn) s0_valid_reg <= 1'b0;
        else if (adv) s0_valid_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_qi_reg  <= QW'(setup.q0) * QW'(in_index);
            s0_ri_reg  <= (2*SW)'(setup.r0) * (2*SW)'(in_index);
            s0_big_reg <= (in_index >= setup.count);
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_div
        logic          p_valid, p_big;
        logic [SW-1:0] p_rem, p_lo, p_quot;
        logic [TW-1:0] p_qi;
        logic [SW:0]   sh_a, sh_b;
        logic [SW-1:0] rem_a, rem_b;
        logic          q_a, q_b;

        if (k == 0) begin : g_first
            assign p_valid = s0_valid_reg;
            assign p_big   = s0_big_reg;
            assign p_rem   = s0_ri_reg[2*SW-1:SW];
            assign p_lo    = s0_ri_reg[SW-1:0];
            assign p_quot  = '0;
            assign p_qi    = s0_qi_reg[TW-1:0];
        end else begin : g_next
            assign p_valid = dv_valid_reg[k-1];
            assign p_big   = dv_big_reg[k-1];
            assign p_rem   = dv_rem_reg[k-1];
            assign p_lo    = dv_lo_reg[k-1];
            assign p_quot  = dv_quot_reg[k-1];
            assign p_qi    = dv_qi_reg[k-1];
        end

        // Two restoring steps per stage
        always_comb begin
            sh_a  = {p_rem, p_lo[SW-1]};
            q_a   = (sh_a >= {1'b0, setup.dn});
            rem_a = q_a ? SW'(sh_a - {1'b0, setup.dn}) : sh_a[SW-1:0];
            sh_b  = {rem_a, p_lo[SW-2]};
            q_b   = (sh_b >= {1'b0, setup.dn});
            rem_b = q_b ? SW'(sh_b - {1'b0, setup.dn}) : sh_b[SW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) dv_valid_reg[k] <= 1'b0;
            else if (adv) dv_valid_reg[k] <= p_valid;
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_big_reg[k]  <= p_big;
                dv_rem_reg[k]  <= rem_b;
                dv_lo_reg[k]   <= {p_lo[SW-3:0], 2'b00};
                dv_quot_reg[k] <= {p_quot[SW-3:0], q_a, q_b};
                dv_qi_reg[k]   <= p_qi;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) t_valid_reg <= 1'b0;
        else if (adv) t_valid_reg <= dv_valid_reg[NS-1];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg     <= dv_qi_reg[NS-1] + TW'(dv_quot_reg[NS-1]);
            t_big_reg <= dv_big_reg[NS-1];
        end
    end

    assign out_valid = t_valid_reg;
    assign out_t     = t_reg;
    assign out_big   = t_big_reg;

endmodule

// ----- hw/rtl/tmp_pos.sv -----
module tmp_pos (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [tmp_pkg::TALL_W-1:0]    in_t,
    input  logic                          in_big,
    input  tmp_pkg::tmp_setup_t           setup,
    output logic                          out_valid,
    output logic [tmp_pkg::DATA_W-1:0]    out_val,
    output tmp_pkg::tmp_phase_t           out_phase,
    output logic                          out_big
);
    localparam int W  = tmp_pkg::DATA_W;
    localparam int TW = tmp_pkg::TALL_W;
    localparam int F  = tmp_pkg::FRAC_BITS;
    localparam int PW = 3 * W;

    logic                p1_valid_reg, p1_big_reg;
    tmp_pkg::tmp_phase_t p1_ph_reg, p1_ph;
    logic [W-1:0]        p1_u_reg;
    logic [TW:0]         p1_b_reg;
    logic [TW-1:0]       r_full;
    logic [W-1:0]        r_sat;

    logic                p2_valid_reg, p2_big_reg;
    tmp_pkg::tmp_phase_t p2_ph_reg;
    logic [63:0]         p2_sq_reg;
    logic [TW:0]         p2_b_reg;

    logic                p3_valid_reg, p3_big_reg;
    tmp_pkg::tmp_phase_t p3_ph_reg;
    logic [63:0]         p3_lo_reg, p3_hi_reg;
    logic [63:0]         b_sel;
    logic [W-1:0]        m_sel;

    logic                p4_valid_reg, p4_big_reg;
    tmp_pkg::tmp_phase_t p4_ph_reg;
    logic [W-1:0]        p4_val_reg;
    logic [PW-1:0]       sum, shd;

    // Phase select and the time operand of the square
    always_comb begin
        if (in_t < TW'(setup.t1))
            p1_ph = tmp_pkg::PH_ACCEL;
        else if (in_t < (TW'(setup.t1) + TW'(setup.t2)))
            p1_ph = tmp_pkg::PH_CRUISE;
        else
            p1_ph = tmp_pkg::PH_DECEL;
        r_full = setup.tall - in_t;
        r_sat  = (|r_full[TW-1:W]) ? '1 : r_full[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_ph_reg  <= p1_ph;
            p1_big_reg <= in_big;
            p1_u_reg   <= (p1_ph == tmp_pkg::PH_ACCEL) ? in_t[W-1:0] : r_sat;
            p1_b_reg   <= {in_t, 1'b0} - (TW+1)'(setup.t1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_ph_reg  <= p1_ph_reg;
            p2_big_reg <= p1_big_reg;
            p2_sq_reg  <= 64'(p1_u_reg) * 64'(p1_u_reg);
            p2_b_reg   <= p1_b_reg;
        end
    end

    always_comb begin
        b_sel = (p2_ph_reg == tmp_pkg::PH_CRUISE) ? 64'(p2_b_reg) : p2_sq_reg;
        m_sel = (p2_ph_reg == tmp_pkg::PH_CRUISE) ? setup.v_eff : setup.a_eff;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_ph_reg  <= p2_ph_reg;
            p3_big_reg <= p2_big_reg;
            p3_lo_reg  <= 64'(m_sel) * 64'(b_sel[W-1:0]);
            p3_hi_reg  <= 64'(m_sel) * 64'(b_sel[63:W]);
        end
    end

    always_comb begin
        sum = PW'(p3_lo_reg) + {p3_hi_reg, {W{1'b0}}};
        shd = (p3_ph_reg == tmp_pkg::PH_CRUISE) ? (sum >> (F + 1)) : (sum >> (2 * F + 1));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_ph_reg  <= p3_ph_reg;
            p4_big_reg <= p3_big_reg;
            p4_val_reg <= (|shd[PW-1:W]) ? '1 : shd[W-1:0];
        end
    end

    assign out_valid = p4_valid_reg;
    assign out_val   = p4_val_reg;
    assign out_phase = p4_ph_reg;
    assign out_big   = p4_big_reg;

endmodule

// ----- hw/rtl/trapezoid_motion_profile_core.sv -----
// Trapezoidal motion profile generator. Write travel distance, acceleration
// limit, speed limit and sample count (unsigned Q16.16, count as an integer)
// on the cfg port while no request is in flight. Every write starts a setup
// pass that derives the accel and cruise times through one shared radix-2
// divider and a one-bit-per-cycle square root; s_tready stays low for it.
// After that each request names a sample index and returns one result with
// the position, both times, the phase and an out-of-range flag. Requests are
// taken one per clock unless m_tready holds the pipe; the path has one
// multiply stage, eight two-bit stages of the sample-time divider, one add,
// four position stages and the output register. Back-pressure on m_tready
// stalls the whole pipe.
module trapezoid_motion_profile_core (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration writes
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    // Request stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,   // [15:0] step_index
    // Result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata    // [31:0] position, [63:32] accel_time,
                                     // [95:64] cruise_time, [97:96] phase,
                                     // [98] index_too_big, [103:99] zero
);
    tmp_pkg::tmp_setup_t          setup;
    logic                         adv;
    logic                         t_valid, t_big;
    logic [tmp_pkg::TALL_W-1:0]   t_val;
    logic                         p_valid, p_big;
    logic [tmp_pkg::DATA_W-1:0]   p_val;
    tmp_pkg::tmp_phase_t          p_phase;

    logic                         m_valid_reg;
    logic [tmp_pkg::DATA_W-1:0]   m_pos_reg, m_t1_reg, m_t2_reg;
    tmp_pkg::tmp_phase_t          m_phase_reg;
    logic                         m_big_reg;
    logic [tmp_pkg::DATA_W-1:0]   pos_next;
    tmp_pkg::tmp_phase_t          phase_next;

    // Advance every stage together whenever the output slot is free or taken
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv && setup.ready;

    tmp_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .setup     (setup)
    );

    tmp_time u_time (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid && s_tready),
        .in_index  (s_tdata),
        .setup     (setup),
        .out_valid (t_valid),
        .out_t     (t_val),
        .out_big   (t_big)
    );

    tmp_pos u_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (t_valid),
        .in_t      (t_val),
        .in_big    (t_big),
        .setup     (setup),
        .out_valid (p_valid),
        .out_val   (p_val),
        .out_phase (p_phase),
        .out_big   (p_big)
    );

    // Decel subtracts the remaining distance from the target, floored at zero;
    // an out-of-range index reports the full distance in the decel phase.
    always_comb begin
        if (p_big) begin
            pos_next   = setup.distance;
            phase_next = tmp_pkg::PH_DECEL;
        end else if (p_phase == tmp_pkg::PH_DECEL) begin
            pos_next   = (setup.distance > p_val) ? setup.distance - p_val : '0;
            phase_next = p_phase;
        end else begin
            pos_next   = p_val;
            phase_next = p_phase;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (adv) m_valid_reg <= p_valid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_pos_reg   <= pos_next;
            m_t1_reg    <= setup.t1;
            m_t2_reg    <= setup.t2;
            m_phase_reg <= phase_next;
            m_big_reg   <= p_big;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_big_reg, m_phase_reg, m_t2_reg, m_t1_reg, m_pos_reg};

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected profile sample, as the block should report it
    typedef struct {
        logic [31:0] position;
        logic [31:0] accel_time;
        logic [31:0] cruise_time;
        logic [1:0]  phase;
        logic        index_too_big;
    } sample_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = '0;
    logic [31:0]   cfg_data = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [15:0]   s_tdata = '0;      // [15:0] step_index
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [103:0]  m_tdata;           // [31:0] position, [63:32] accel_time,
                                      // [95:64] cruise_time, [97:96] phase,
                                      // [98] index_too_big

    int  mismatches = 0;
    int  results_seen = 0;
    int  configs_seen = 0;
    bit  hold_off_req = 1'b0;   // ask the receiver for one long stall
    bit  stim_done = 1'b0;

    always #1 aclk = ~aclk;

    trapezoid_motion_profile_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // Local copy of the profile settings plus the pending samples
    class profile_scoreboard;
        logic [31:0] distance;
        logic [31:0] accel;
        logic [31:0] speed;
        logic [15:0] count;
        sample_t     pending[$];

        function new();
            distance = 0;
            accel = 32'h0001_0000;
            speed = 32'h0001_0000;
            count = 16'd100;
        endfunction

        function void write_reg(tmp_pkg::tmp_reg_t idx, logic [31:0] val);
            case (idx)
                tmp_pkg::REG_DIST:  distance = val;
                tmp_pkg::REG_ACCEL: accel = val;
                tmp_pkg::REG_SPEED: speed = val;
                tmp_pkg::REG_COUNT: count = val[15:0];
                default: ;
            endcase
        endfunction

        static function logic [63:0] root_floor(logic [63:0] x);
            logic [63:0] rem, res, b;
            rem = x;
            res = 0;
            b = 64'd1 << 62;
            while (b > rem) b = b >> 2;
            while (b != 0) begin
                if (rem >= res + b) begin
                    rem = rem - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // floor(a*b / 2^s), saturated to 32 bits
        static function logic [31:0] scale_sat(logic [31:0] a, logic [63:0] b, int s);
            logic [95:0] p;
            p = {64'd0, a} * {32'd0, b};
            p = p >> s;
            return (|p[95:32]) ? 32'hFFFF_FFFF : p[31:0];
        endfunction

        static function logic [31:0] clip32(logic [63:0] v);
            return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        function void note_request(logic [15:0] idx);
            logic [63:0] x, a, v, n, t1, t2, tall, t, d1, vp, r, dec;
            logic [127:0] prod;
            sample_t s;
            x = distance;
            a = (accel != 0) ? accel : 1;
            v = (speed != 0) ? speed : 1;
            n = count;
            if (v * v > x * a) begin
                vp = root_floor(x * a);
                t1 = clip32((vp << tmp_pkg::FRAC_BITS) / a);
                t2 = 0;
            end else begin
                d1 = (v * v) / (2 * a);
                t1 = clip32((v << tmp_pkg::FRAC_BITS) / a);
                t2 = clip32(((x - 2 * d1) << tmp_pkg::FRAC_BITS) / v);
            end
            s.accel_time = t1[31:0];
            s.cruise_time = t2[31:0];
            s.index_too_big = 1'b0;
            if (idx >= n) begin
                s.position = distance;
                s.phase = tmp_pkg::PH_DECEL;
                s.index_too_big = 1'b1;
            end else begin
                tall = 2 * t1 + t2;
                prod = {64'd0, tall} * idx;
                t = (n >= 2) ? 64'(prod / (n - 1)) : 0;
                if (t < t1) begin
                    s.position = scale_sat(a[31:0], t * t, 2 * tmp_pkg::FRAC_BITS + 1);
                    s.phase = tmp_pkg::PH_ACCEL;
                end else if (t < t1 + t2) begin
                    s.position = scale_sat(v[31:0], 2 * t - t1, tmp_pkg::FRAC_BITS + 1);
                    s.phase = tmp_pkg::PH_CRUISE;
                end else begin
                    r = (tall >= t) ? tall - t : 0;
                    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
                    dec = scale_sat(a[31:0], r * r, 2 * tmp_pkg::FRAC_BITS + 1);
                    s.position = (x > dec) ? 32'(x - dec) : 32'd0;
                    s.phase = tmp_pkg::PH_DECEL;
                end
            end
            pending.push_back(s);
        endfunction

        task check_result(logic [103:0] d);
            sample_t e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", d[31:0], 32'd0);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.position) report_mismatch("position", d[31:0], e.position);
            if (d[63:32] !== e.accel_time)
                report_mismatch("accel_time", d[63:32], e.accel_time);
            if (d[95:64] !== e.cruise_time)
                report_mismatch("cruise_time", d[95:64], e.cruise_time);
            if (d[97:96] !== e.phase)
                report_mismatch("phase", 32'(d[97:96]), 32'(e.phase));
            if (d[98] !== e.index_too_big)
                report_mismatch("index_too_big", 32'(d[98]), 32'(e.index_too_big));
        endtask
    endclass

    profile_scoreboard sb = new();

    // Write one register and mirror it in the scoreboard
    task automatic write_cfg(input tmp_pkg::tmp_reg_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        configs_seen++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_profile(input logic [31:0] x, input logic [31:0] a,
                                input logic [31:0] v, input logic [15:0] n);
        write_cfg(tmp_pkg::REG_DIST, x);
        write_cfg(tmp_pkg::REG_ACCEL, a);
        write_cfg(tmp_pkg::REG_SPEED, v);
        write_cfg(tmp_pkg::REG_COUNT, {16'd0, n});
    endtask

    // Offer one request, honoring a random gap first; valid stays up across
    // back-to-back requests
    task automatic send_step(input logic [15:0] idx, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= idx;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(idx);
        @(negedge aclk);
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
    endtask

    // Drain every pending sample, then let the pipe settle
    task automatic drain();
        idle_sender();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // Mostly indices from zero to just past the count, sometimes the full range
    function automatic logic [15:0] pick_index();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'($urandom);
        if (sel == 1) return sb.count;
        if (sb.count == 0) return 16'($urandom_range(0, 3));
        return 16'($urandom_range(0, sb.count + 1));
    endfunction

    // Receiver: random stalls, one long hold-off on request
    initial begin
        int wait_cycles;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (200) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
            results_seen++;
        end
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int k, p;
        logic [31:0] x, a, v;
        logic [15:0] n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset profile, then extremes and special cases
        send_step(16'd0, 0);
        send_step(16'd99, 0);
        send_step(16'd100, 0);
        send_step(16'hFFFF, 0);
        drain();
        load_profile(32'h0064_0000, 32'h0001_0000, 32'h0002_0000, 16'd11);
        for (k = 0; k <= 11; k++) send_step(16'(k), 0);   // trapezoid, all phases
        drain();
        load_profile(32'h0000_8000, 32'h0002_0000, 32'h0010_0000, 16'd1);
        send_step(16'd0, 0);                 // single sample
        send_step(16'd1, 0);
        drain();
        load_profile(32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0);   // zero limits, no samples
        send_step(16'd0, 0);
        send_step(16'h5A5A, 0);
        drain();
        load_profile(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_step(16'hFFFE, 0);
        send_step(16'h7FFF, 0);
        send_step(16'hFFFF, 0);
        drain();
        load_profile(32'd0, 32'd1, 32'd1, 16'd2);
        send_step(16'd0, 0);
        send_step(16'd1, 0);
        drain();

        // Random phases, each under a fresh profile
        for (p = 0; p < 24; p++) begin
            case ($urandom_range(0, 3))
                0: x = $urandom;
                1: x = $urandom_range(0, 32'h00FF_FFFF);
                2: x = 32'hFFFF_FFFF;
                default: x = $urandom_range(0, 32'h0000_FFFF);
            endcase
            a = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
            v = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
            n = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
            if (p == 5) n = 16'hFFFF;
            if (p == 6) n = 16'd0;
            load_profile(x, a, v, n);
            if (p == 3) hold_off_req = 1'b1;
            for (k = 0; k < 50; k++) begin
                send_step(pick_index(), (p % 4) != 1);
                if (p == 7 && k == 25) begin
                    // pause until all outstanding samples are back
                    idle_sender();
                    while (sb.pending.size() != 0) @(negedge aclk);
                end
            end
            drain();
        end
        stim_done = 1'b1;

        $display("ran %0d profile register writes and %0d samples", configs_seen,
                 results_seen);
        $display("covered triangular and trapezoid shapes, all phases, out-of-range indices");
        if (mismatches == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
